// File: src/hta_pkg.sv
// shared constants for the heron triangle area pipeline
// no dependencies
package hta_pkg;

  localparam int COORD_WIDTH_DEF    = 16;
  localparam int AREA_FRAC_BITS_DEF = 8;
  localparam int SIDE_FRAC          = 16;
  localparam int AREA_W             = 41;

endpackage

// File: src/hta_mul.sv
// pipelined shift-add multiplier, one multiplier bit per stage
// carries a valid bit and a side-band tag alongside the product
module hta_mul #(
  parameter int AW = 35,
  parameter int BW = 34,
  parameter int TW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  input  logic [TW-1:0]      in_tag,
  output logic               out_valid,
  output logic [AW+BW-1:0]   prod,
  output logic [TW-1:0]      out_tag
);

  localparam int PW = AW + BW;

  logic              vld [1:BW];
  logic [PW-1:0]     acc [1:BW];
  logic [PW-1:0]     opa [1:BW];
  logic [BW-1:0]     opb [1:BW];
  logic [TW-1:0]     tag [1:BW];

  for (genvar i = 0; i < BW; i++) begin : g_stage
    logic          v_in;
    logic [PW-1:0] acc_in;
    logic [PW-1:0] a_in;
    logic [BW-1:0] b_in;
    logic [TW-1:0] t_in;
    logic [PW-1:0] acc_next;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign acc_in = '0;
      assign a_in   = PW'(a);
      assign b_in   = b;
      assign t_in   = in_tag;
    end else begin : g_rest
      assign v_in   = vld[i];
      assign acc_in = acc[i];
      assign a_in   = opa[i];
      assign b_in   = opb[i];
      assign t_in   = tag[i];
    end

    assign acc_next = b_in[i] ? acc_in + (a_in << i) : acc_in;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= v_in;
      end
      acc[i+1] <= acc_next;
      opa[i+1] <= a_in;
      opb[i+1] <= b_in;
      tag[i+1] <= t_in;
    end
  end

  assign out_valid = vld[BW];
  assign prod      = acc[BW];
  assign out_tag   = tag[BW];

endmodule

// File: src/hta_sqrt.sv
// pipelined restoring integer square root, one root bit per stage
// carries a valid bit alongside the remainder and partial root
module hta_sqrt #(
  parameter int RW = 33
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   radicand,
  output logic              out_valid,
  output logic [RW-1:0]     root
);

  localparam int NW = 2 * RW;

  logic            vld [1:RW];
  logic [NW-1:0]   rad [1:RW];
  logic [RW+1:0]   rem [1:RW];
  logic [RW-1:0]   rt  [1:RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] rad_in;
    logic [RW+1:0] rem_in;
    logic [RW-1:0] rt_in;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rad_in = radicand;
      assign rem_in = '0;
      assign rt_in  = '0;
    end else begin : g_rest
      assign v_in   = vld[i];
      assign rad_in = rad[i];
      assign rem_in = rem[i];
      assign rt_in  = rt[i];
    end

    assign rem_sh = {rem_in[RW-1:0], rad_in[NW-1 -: 2]};
    assign trial  = {rt_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= v_in;
      end
      rad[i+1] <= rad_in << 2;
      rem[i+1] <= ge ? rem_sh - trial : rem_sh;
      rt[i+1]  <= {rt_in[RW-2:0], ge};
    end
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];

endmodule

// File: src/triangle_area_heron.sv
// Triangle area by Heron's formula: a beat enters on every cycle with start high (busy stays
// low), and its area appears on tri_area with done high for one cycle. A beat passes in order
// through the registered squared coordinate differences, the registered squared side lengths,
// the bit-per-stage side roots, the degenerate-check register, the three shift-add multipliers,
// the final root and the output register. The receiver cannot stall, and none is needed.
// depends on hta_pkg, hta_mul, hta_sqrt
module triangle_area_heron #(
  parameter int COORD_WIDTH    = hta_pkg::COORD_WIDTH_DEF,
  parameter int AREA_FRAC_BITS = hta_pkg::AREA_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] cz,
  output logic                          done,
  output logic [hta_pkg::AREA_W-1:0]    tri_area
);

  import hta_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int SQW    = 2 * CW;
  localparam int D2W    = 2 * CW + 2;
  localparam int SIDE_W = (D2W + 2 * SIDE_FRAC) / 2;
  localparam int SW     = SIDE_W + 2;
  localparam int XW     = SIDE_W + 1;
  localparam int P1W    = SW + XW;
  localparam int P2W    = P1W + XW;
  localparam int P3W    = P2W + XW;
  localparam int K      = 4 * SIDE_FRAC + 4 - 2 * AREA_FRAC_BITS;
  localparam int RW     = (P3W - K + 1) / 2;
  localparam int EW     = (RW > AREA_W) ? RW : AREA_W;

  logic signed [CW-1:0] pt [3][3];
  logic [SQW-1:0]       sq_next [3][3];
  logic [SQW-1:0]       sq [3][3];
  logic                 v1;
  logic [D2W-1:0]       d2 [3];
  logic                 v2;

  assign busy = 1'b0;

  assign pt[0][0] = ax;
  assign pt[0][1] = ay;
  assign pt[0][2] = az;
  assign pt[1][0] = bx;
  assign pt[1][1] = by;
  assign pt[1][2] = bz;
  assign pt[2][0] = cx;
  assign pt[2][1] = cy;
  assign pt[2][2] = cz;

  // side k runs from corner k to corner k+1 (mod 3): a = AB, b = BC, c = CA
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        logic signed [CW:0] d;
        logic [CW-1:0]      m;
        d = {pt[k][j][CW-1], pt[k][j]} - {pt[(k+1)%3][j][CW-1], pt[(k+1)%3][j]};
        m = d[CW] ? CW'(-d) : d[CW-1:0];
        sq_next[k][j] = m * m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
    end
    sq <= sq_next;
    for (int k = 0; k < 3; k++) begin
      d2[k] <= D2W'(sq[k][0]) + D2W'(sq[k][1]) + D2W'(sq[k][2]);
    end
  end

  logic              v3 [3];
  logic [SIDE_W-1:0] side [3];

  for (genvar k = 0; k < 3; k++) begin : g_side
    hta_sqrt #(.RW(SIDE_W)) u_sqrt (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v2),
      .radicand  ({d2[k], (2*SIDE_FRAC)'(0)}),
      .out_valid (v3[k]),
      .root      (side[k])
    );
  end

  logic signed [SIDE_W+2:0] ss, xs, ys, zs;
  logic                     degen;
  logic                     v4;
  logic [SW-1:0]            s_r;
  logic [XW-1:0]            x_r, y_r, z_r;

  always_comb begin
    ss = $signed({3'b0, side[0]}) + $signed({3'b0, side[1]}) + $signed({3'b0, side[2]});
    xs = $signed({3'b0, side[1]}) + $signed({3'b0, side[2]}) - $signed({3'b0, side[0]});
    ys = $signed({3'b0, side[0]}) + $signed({3'b0, side[2]}) - $signed({3'b0, side[1]});
    zs = $signed({3'b0, side[0]}) + $signed({3'b0, side[1]}) - $signed({3'b0, side[2]});
    degen = (ss <= 0) || (xs <= 0) || (ys <= 0) || (zs <= 0);
  end

  // degenerate triangles feed zeros, so the product and root come out zero
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3[0];
    end
    s_r <= degen ? '0 : ss[SW-1:0];
    x_r <= degen ? '0 : xs[XW-1:0];
    y_r <= degen ? '0 : ys[XW-1:0];
    z_r <= degen ? '0 : zs[XW-1:0];
  end

  logic           v5, v6, v7;
  logic [P1W-1:0] p1;
  logic [P2W-1:0] p2;
  logic [P3W-1:0] p3;
  logic [XW-1:0]  y5, z5, z6;
  logic           t7;

  hta_mul #(.AW(SW), .BW(XW), .TW(2*XW)) u_mul1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .a         (s_r),
    .b         (x_r),
    .in_tag    ({y_r, z_r}),
    .out_valid (v5),
    .prod      (p1),
    .out_tag   ({y5, z5})
  );

  hta_mul #(.AW(P1W), .BW(XW), .TW(XW)) u_mul2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .a         (p1),
    .b         (y5),
    .in_tag    (z5),
    .out_valid (v6),
    .prod      (p2),
    .out_tag   (z6)
  );

  hta_mul #(.AW(P2W), .BW(XW), .TW(1)) u_mul3 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .a         (p2),
    .b         (z6),
    .in_tag    (1'b0),
    .out_valid (v7),
    .prod      (p3),
    .out_tag   (t7)
  );

  logic          v8;
  logic [RW-1:0] root;
  logic [EW-1:0] root_ext;

  hta_sqrt #(.RW(RW)) u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7 | (t7 & 1'b0)),
    .radicand  ((2*RW)'(p3 >> K)),
    .out_valid (v8),
    .root      (root)
  );

  assign root_ext = EW'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v8;
    end
    tri_area <= root_ext[AREA_W-1:0];
  end

endmodule
